// File: hw/rtl/gppb_pkg.sv
package gppb_pkg;

  // Neighbor taps fetched from the history for every pixel
  localparam int NB_COUNT = 40;
  localparam int NB_IDX_W = $clog2(NB_COUNT);

  // Predictors emitted per pixel
  localparam int PRED_COUNT = 55;
  localparam logic [5:0] PRED_LAST = 6'(PRED_COUNT - 1);

  typedef logic signed [15:0] num_t;
  typedef logic [NB_COUNT-1:0][7:0] nbr_t;

  typedef enum logic [2:0] {
    DIV1  = 3'd0,
    DIV2  = 3'd1,
    DIV3  = 3'd2,
    DIV4  = 3'd3,
    DIV5  = 3'd4,
    DIV6  = 3'd5,
    DIV10 = 3'd6
  } div_t;

  typedef struct packed {
    num_t num;
    div_t div;
  } arm_t;

  // Tap distance back into the history is row * width + col
  // (col positive toward west, negative toward east).
  localparam logic [2:0] NB_ROW [NB_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4,
    3'd5, 3'd6
  };

  localparam logic signed [3:0] NB_COL [NB_COUNT] = '{
    4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd5, 4'sd6,
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4,
    -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd6, -4'sd7,
    4'sd0, 4'sd1, 4'sd2, 4'sd3,
    -4'sd1, -4'sd2, -4'sd3, -4'sd4,
    4'sd0, 4'sd1, 4'sd2, 4'sd4, 4'sd5,
    -4'sd1, -4'sd2, -4'sd3, -4'sd4,
    4'sd0, 4'sd3, -4'sd3,
    4'sd0, 4'sd0
  };

  localparam logic [15:0] RECIP3  = 16'd21846;
  localparam logic [15:0] RECIP5  = 16'd13108;
  localparam logic [15:0] RECIP6  = 16'd10923;
  localparam logic [15:0] RECIP10 = 16'd6554;

  function automatic num_t clip8(input num_t v);
    return (v < 16'sd0) ? 16'sd0 : ((v > 16'sd255) ? 16'sd255 : v);
  endfunction

  function automatic num_t clamp4(input num_t v, input num_t a, input num_t b,
                                  input num_t c, input num_t d);
    num_t lo;
    num_t hi;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    if (c < lo) lo = c;
    if (c > hi) hi = c;
    if (d < lo) lo = d;
    if (d > hi) hi = d;
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Truncating division toward zero by a small constant: magnitude times
  // reciprocal, exact for magnitudes below 16384.
  function automatic num_t div_trunc(input num_t v, input div_t d);
    logic [15:0] mag;
    logic [13:0] a;
    logic [15:0] recip;
    logic [29:0] prod;
    logic [13:0] q;
    logic        use_mul;
    mag = v[15] ? 16'(-v) : 16'(v);
    a = mag[13:0];
    recip = '0;
    use_mul = 1'b0;
    q = a;
    case (d)
      DIV2:  q = a >> 1;
      DIV4:  q = a >> 2;
      DIV3:  begin recip = RECIP3;  use_mul = 1'b1; end
      DIV5:  begin recip = RECIP5;  use_mul = 1'b1; end
      DIV6:  begin recip = RECIP6;  use_mul = 1'b1; end
      DIV10: begin recip = RECIP10; use_mul = 1'b1; end
      default: q = a;
    endcase
    prod = 30'(a) * 30'(recip);
    if (use_mul) q = prod[29:16];
    return v[15] ? -num_t'({2'b00, q}) : num_t'({2'b00, q});
  endfunction

  // Numerator and divisor of one predictor
  function automatic arm_t pred_arm(input logic [5:0] idx, input nbr_t nb);
    arm_t r;
    num_t W, WW, WWW, WWWW, WWWWW, WWWWWW;
    num_t N, NW, NWW, NWWW, NWWWW;
    num_t NE, NEE, NEEE, NEEEE, NEEEEE, NEEEEEE, NEEEEEEE;
    num_t NN, NNW, NNWW, NNWWW, NNE, NNEE, NNEEE, NNEEEE;
    num_t NNN, NNNW, NNNWW, NNNWWWW, NNNWWWWW, NNNE, NNNEE, NNNEEE, NNNEEEE;
    num_t NNNN, NNNNWWW, NNNNEEE, NNNNN, NNNNNN;
    W        = {8'h00, nb[0]};
    WW       = {8'h00, nb[1]};
    WWW      = {8'h00, nb[2]};
    WWWW     = {8'h00, nb[3]};
    WWWWW    = {8'h00, nb[4]};
    WWWWWW   = {8'h00, nb[5]};
    N        = {8'h00, nb[6]};
    NW       = {8'h00, nb[7]};
    NWW      = {8'h00, nb[8]};
    NWWW     = {8'h00, nb[9]};
    NWWWW    = {8'h00, nb[10]};
    NE       = {8'h00, nb[11]};
    NEE      = {8'h00, nb[12]};
    NEEE     = {8'h00, nb[13]};
    NEEEE    = {8'h00, nb[14]};
    NEEEEE   = {8'h00, nb[15]};
    NEEEEEE  = {8'h00, nb[16]};
    NEEEEEEE = {8'h00, nb[17]};
    NN       = {8'h00, nb[18]};
    NNW      = {8'h00, nb[19]};
    NNWW     = {8'h00, nb[20]};
    NNWWW    = {8'h00, nb[21]};
    NNE      = {8'h00, nb[22]};
    NNEE     = {8'h00, nb[23]};
    NNEEE    = {8'h00, nb[24]};
    NNEEEE   = {8'h00, nb[25]};
    NNN      = {8'h00, nb[26]};
    NNNW     = {8'h00, nb[27]};
    NNNWW    = {8'h00, nb[28]};
    NNNWWWW  = {8'h00, nb[29]};
    NNNWWWWW = {8'h00, nb[30]};
    NNNE     = {8'h00, nb[31]};
    NNNEE    = {8'h00, nb[32]};
    NNNEEE   = {8'h00, nb[33]};
    NNNEEEE  = {8'h00, nb[34]};
    NNNN     = {8'h00, nb[35]};
    NNNNWWW  = {8'h00, nb[36]};
    NNNNEEE  = {8'h00, nb[37]};
    NNNNN    = {8'h00, nb[38]};
    NNNNNN   = {8'h00, nb[39]};
    r.num = 16'sd0;
    r.div = DIV1;
    case (idx)
      6'd0:  r.num = clamp4(W + N - NW, W, NW, N, NE);
      6'd1:  r.num = W + N - NW;
      6'd2:  r.num = clamp4(W + NE - N, W, NW, N, NE);
      6'd3:  r.num = W + NE - N;
      6'd4:  r.num = clamp4(N + NW - NNW, W, NW, N, NE);
      6'd5:  r.num = N + NW - NNW;
      6'd6:  r.num = clamp4(N + NE - NNE, W, N, NE, NEE);
      6'd7:  r.num = N + NE - NNE;
      6'd8:  begin r.num = W + NEE; r.div = DIV2; end
      6'd9:  r.num = N * 16'sd3 - NN * 16'sd3 + NNN;
      6'd10: r.num = W * 16'sd3 - WW * 16'sd3 + WWW;
      6'd11: begin
        r.num = W + clip8(NE * 16'sd3 - NNE * 16'sd3 + NNNE);
        r.div = DIV2;
      end
      6'd12: begin
        r.num = W + clip8(NEE * 16'sd3 - NNEEE * 16'sd3 + NNNEEEE);
        r.div = DIV2;
      end
      6'd13: r.num = NN + NNNN - NNNNNN;
      6'd14: r.num = WW + WWWW - WWWWWW;
      6'd15: begin
        r.num = NNNNN - NNNN * 16'sd6 + NNN * 16'sd15 - NN * 16'sd20 + N * 16'sd15
              + clamp4(W * 16'sd2 - NWW, W, NW, N, NN);
        r.div = DIV6;
      end
      6'd16: begin
        r.num = W * 16'sd8 - WW * 16'sd3
              + clamp4(NEE * 16'sd3 - NNEE * 16'sd3 + NNNEE, NE, NEE, NEEE, NEEEE);
        r.div = DIV6;
      end
      6'd17: r.num = NN + NW - NNNW;
      6'd18: r.num = NN + NE - NNNE;
      6'd19: r.num = W * 16'sd2 + NW - WW - NWW * 16'sd2 + NWWW;
      6'd20: r.num = ((NW + NWW) >>> 1) * 16'sd3 - NNWWW * 16'sd3
                   + ((NNNWWWW + NNNWWWWW) >>> 1);
      6'd21: r.num = NEE + NE - NNEEE;
      6'd22: r.num = NWW + WW - NWWWW;
      6'd23: begin
        r.num = (W + NW) * 16'sd3 - NWW * 16'sd6 + NWWW + NNWWW;
        r.div = DIV2;
      end
      6'd24: r.num = NE * 16'sd2 + NNE - NNEE - NNNEE * 16'sd2 + NNNNEEE;
      6'd25: r.num = NNNNNN;
      6'd26: begin r.num = NEEEE + NEEEEEE; r.div = DIV2; end
      6'd27: begin r.num = WWWW + WWWWWW; r.div = DIV2; end
      6'd28: begin r.num = W + N + NEEEEE + NEEEEEEE; r.div = DIV4; end
      6'd29: r.num = NEEE + W - NEE;
      6'd30: r.num = NNN * 16'sd4 - NNNN * 16'sd3;
      6'd31: r.num = N + NN - NNN;
      6'd32: r.num = W + WW - WWW;
      6'd33: r.num = W + NEE - NE;
      6'd34: r.num = WW + NEE - N;
      6'd35: begin
        r.num = clip8(W * 16'sd2 - NW) + clip8(W * 16'sd2 - NWW) + N + NE;
        r.div = DIV4;
      end
      6'd36: r.num = clamp4(N * 16'sd2 - NN, W, N, NE, NEE);
      6'd37: begin r.num = N + NNN; r.div = DIV2; end
      6'd38: r.num = NN + W - NNW;
      6'd39: r.num = NWW + N - NNWW;
      6'd40: begin
        r.num = WWW * 16'sd4 - WW * 16'sd15 + W * 16'sd20 + clip8(NEE * 16'sd2 - NNEE);
        r.div = DIV10;
      end
      6'd41: begin
        r.num = NNNEEE - NNEE * 16'sd4 + NE * 16'sd6
              + clip8(W * 16'sd3 - NW * 16'sd3 + NNW);
        r.div = DIV4;
      end
      6'd42: r.num = N * 16'sd2 + NE - NN - NNE * 16'sd2 + NNNE;
      6'd43: r.num = NW * 16'sd2 + NNW - NNWW - NNNWW * 16'sd2 + NNNNWWW;
      6'd44: r.num = NNWW + W - NNWWW;
      6'd45: begin
        r.num = NNN * 16'sd5 - NNNN - NN * 16'sd10 + N * 16'sd10
              + clip8(W * 16'sd4 - NWW * 16'sd6 + NNWWW * 16'sd4 - NNNWWWW);
        r.div = DIV5;
      end
      6'd46: r.num = NEE + clip8(NEEE * 16'sd2 - NNEEEE) - NEEEE;
      6'd47: r.num = NW + W - NWW;
      6'd48: r.num = N * 16'sd2 + NW - NN - NNW * 16'sd2 + NNNW;
      6'd49: r.num = NN + clip8(NEE * 16'sd2 - NNEEE) - NNE;
      6'd50: begin
        r.num = WWW * 16'sd5 - WWWW - WW * 16'sd10 + W * 16'sd10
              + clip8(NE * 16'sd2 - NNE);
        r.div = DIV5;
      end
      6'd51: begin
        r.num = WWWW * 16'sd4 - WWWWW - WWW * 16'sd5 + W * 16'sd5
              + clip8(NE * 16'sd2 - NNE);
        r.div = DIV4;
      end
      6'd52: begin
        r.num = WWW - WW * 16'sd4 + W * 16'sd6
              + clip8(NE * 16'sd3 - NNE * 16'sd3 + NNNE);
        r.div = DIV4;
      end
      6'd53: begin
        r.num = NE * 16'sd3 - NNEE
              + clip8(W * 16'sd4 - NW * 16'sd6 + NNW * 16'sd4 - NNNW);
        r.div = DIV3;
      end
      6'd54: begin
        r.num = (W + N) * 16'sd3 - NW * 16'sd2;
        r.div = DIV4;
      end
      default: r.num = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/gray_pixel_predictor_bank.sv
// Gray pixel predictor bank.
// Input channel: pixel with pixel_valid / pixel_stall; a beat moves when
// valid is high and stall is low. Each pixel is appended to a circular history
// and the block then emits 55 result beats for the next pixel, predictors
// 0 to 54 in order, with last_prediction high on predictor 54.
// Output channel: predictor_index, prediction, last_prediction with
// result_valid / result_stall. Holding result_stall freezes the output
// register and the stage behind it; the input side keeps taking one more
// pixel into its buffer, then raises pixel_stall.
// Config: cfg_we writes cfg_wdata into image_width (reset 256); write it
// only while idle. Values outside 8..MAX_WIDTH are saturated.
// Throughput: one result beat per cycle while result_stall is low, set by the
// result channel. Behind it, 40 history taps are read one per cycle from
// the history memory into a second tap bank, so fetching for the next pixel
// overlaps the results of the current one.
// Reset clears control state only; history entries not yet written since
// reset read as zero via the write pointer and a wrapped flag, so no
// clearing pass is needed.
module gray_pixel_predictor_bank
  import gppb_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata,
  input  logic [7:0]        pixel,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output logic [5:0]        predictor_index,
  output logic signed [9:0] prediction,
  output logic              last_prediction,
  output logic              result_valid,
  input  logic              result_stall
);

  localparam int HIST_DEPTH = 6 * MAX_WIDTH + 8;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int OFF_W      = PTR_W + 1;
  localparam int W_W        = $clog2(MAX_WIDTH + 1);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_READ  = 4'b0010,
    F_DRAIN = 4'b0100,
    F_FULL  = 4'b1000
  } fstate_t;

  logic [12:0]         image_width;
  logic [W_W-1:0]      w_sat;

  logic                buf_full;
  logic [7:0]          buf_pixel;
  logic                pixel_take;

  fstate_t             fstate;
  logic [PTR_W-1:0]    wr_ptr;
  logic                wrapped;
  logic                mem_we;
  logic [NB_IDX_W-1:0] rd_cnt;
  logic [NB_IDX_W-1:0] cap_idx;
  logic                cap_valid;

  logic [7:0]          mem [HIST_DEPTH];
  logic [7:0]          rd_data;
  logic                rd_ok;
  logic [PTR_W-1:0]    rd_addr;
  logic                rd_borrow;
  logic [OFF_W-1:0]    row_term;
  logic [OFF_W-1:0]    col_term;
  logic [OFF_W-1:0]    offset;
  logic [OFF_W-1:0]    diff;
  logic [OFF_W-1:0]    diff_wrap;

  nbr_t                nb_fetch;
  nbr_t                nb_emit;

  logic                emit_busy;
  logic [5:0]          emit_idx;
  logic                issue;
  logic                issue_last;
  logic                load;

  logic                s1_valid;
  num_t                s1_num;
  div_t                s1_div;
  logic [5:0]          s1_idx;
  logic                s1_ready;
  logic                s2_ready;
  arm_t                arm;
  num_t                quot;
  num_t                final_val;

  // Config register and width saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd256;
    end else if (cfg_we) begin
      image_width <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(image_width) < 32'd8) begin
      w_sat = W_W'(8);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_sat = W_W'(MAX_WIDTH);
    end else begin
      w_sat = W_W'(image_width);
    end
  end

  // Input buffer: hold one pixel until the fetch side takes it
  assign pixel_stall = buf_full;
  assign pixel_take  = pixel_valid && !buf_full;
  assign mem_we      = (fstate == F_IDLE) && buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
    end else if (pixel_take) begin
      buf_full <= 1'b1;
    end else if (mem_we) begin
      buf_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      buf_pixel <= pixel;
    end
  end

  // Fetch sequencer: write the pixel, then read the 40 taps one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate    <= F_IDLE;
      wr_ptr    <= '0;
      wrapped   <= 1'b0;
      rd_cnt    <= '0;
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= (fstate == F_READ);
      unique case (fstate)
        F_IDLE: begin
          if (buf_full) begin
            if (wr_ptr == PTR_W'(HIST_DEPTH - 1)) begin
              wr_ptr  <= '0;
              wrapped <= 1'b1;
            end else begin
              wr_ptr <= wr_ptr + 1'b1;
            end
            rd_cnt <= '0;
            fstate <= F_READ;
          end
        end
        F_READ: begin
          if (rd_cnt == NB_IDX_W'(NB_COUNT - 1)) begin
            fstate <= F_DRAIN;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        F_DRAIN: begin
          fstate <= F_FULL;
        end
        F_FULL: begin
          if (load) begin
            fstate <= F_IDLE;
          end
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

  // Tap address: wr_ptr minus row * width + col, wrapped into the history
  always_comb begin
    row_term  = OFF_W'(NB_ROW[rd_cnt]) * OFF_W'(w_sat);
    col_term  = {{(OFF_W - 4){NB_COL[rd_cnt][3]}}, NB_COL[rd_cnt]};
    offset    = row_term + col_term;
    diff      = {1'b0, wr_ptr} - offset;
    rd_borrow = diff[OFF_W-1];
    diff_wrap = diff + OFF_W'(HIST_DEPTH);
    rd_addr   = rd_borrow ? diff_wrap[PTR_W-1:0] : diff[PTR_W-1:0];
  end

  // History memory; an entry behind the pointer that wrapped before the
  // first lap is complete was never written and reads as zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= buf_pixel;
    end
    rd_data <= mem[rd_addr];
    rd_ok   <= wrapped || !rd_borrow;
  end

  always_ff @(posedge clk) begin
    cap_idx <= rd_cnt;
    if (cap_valid) begin
      nb_fetch[cap_idx] <= rd_ok ? rd_data : 8'h00;
    end
  end

  // Result sequencer: walk the predictors over the loaded tap bank
  assign s2_ready   = !result_valid || !result_stall;
  assign s1_ready   = !s1_valid || s2_ready;
  assign issue      = emit_busy && s1_ready;
  assign issue_last = issue && (emit_idx == PRED_LAST);
  assign load       = (fstate == F_FULL) && (!emit_busy || issue_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_idx  <= '0;
    end else begin
      if (load) begin
        emit_busy <= 1'b1;
      end else if (issue_last) begin
        emit_busy <= 1'b0;
      end
      if (issue) begin
        emit_idx <= issue_last ? 6'd0 : emit_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nb_emit <= nb_fetch;
    end
  end

  // Stage 1: numerator and divisor of the selected predictor
  assign arm = pred_arm(emit_idx, nb_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_num <= arm.num;
      s1_div <= arm.div;
      s1_idx <= emit_idx;
    end
  end

  // Stage 2: divide, clip all but the last predictor, drive the output beat
  assign quot      = div_trunc(s1_num, s1_div);
  assign final_val = (s1_idx == PRED_LAST) ? quot : clip8(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      predictor_index <= s1_idx;
      prediction      <= final_val[9:0];
      last_prediction <= (s1_idx == PRED_LAST);
    end
  end

`ifndef NO_ASSERTIONS
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_prediction == (predictor_index == PRED_LAST)))
    else $error("last_prediction does not match predictor index");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    emit_busy |-> (emit_idx <= PRED_LAST))
    else $error("predictor counter past last predictor");

  a_write_then_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (fstate == F_READ) && (rd_cnt == '0))
    else $error("history write not followed by tap reads");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result_valid && result_stall) |=> s1_valid && $stable(s1_idx))
    else $error("stage 1 changed while output stalled");
`endif

endmodule

// File: tb/tb_gray_pixel_predictor_bank.sv
`timescale 1ns / 100ps

module tb_gray_pixel_predictor_bank;
  import gppb_pkg::*;

  localparam int MAX_W      = 4096;
  localparam int HIST_LEN   = 6 * MAX_W + 8;
  localparam int SETTLE     = 80;      // margin past the latency from a pixel beat to its results
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic [5:0]        idx;
    logic signed [9:0] value;
    logic              last;
  } pred_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [12:0]       cfg_wdata = '0;
  logic [7:0]        pixel = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic [5:0]        predictor_index;
  logic signed [9:0] prediction;
  logic              last_prediction;
  logic              result_valid;
  logic              result_stall = 1'b0;

  // Our own copy of the pixel history and the row width
  logic [7:0]  hist [HIST_LEN];
  int          hist_wr;
  int          row_width;

  pred_beat_t  pending_preds [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;

  gray_pixel_predictor_bank uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .pixel          (pixel),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .predictor_index(predictor_index),
    .prediction     (prediction),
    .last_prediction(last_prediction),
    .result_valid   (result_valid),
    .result_stall   (result_stall)
  );

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Neighborhood predictor
  // ---------------------------------------------------------------------------

  // Pixel k positions back from the write pointer (wraps over the whole store)
  function automatic int tap(input int k);
    return int'(hist[(hist_wr + HIST_LEN - (k % HIST_LEN)) % HIST_LEN]);
  endfunction

  function automatic int sat8(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic int limit4(input int v, input int a, input int b, input int c,
                                input int d);
    int lo;
    int hi;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    if (c < lo) lo = c;
    if (c > hi) hi = c;
    if (d < lo) lo = d;
    if (d > hi) hi = d;
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Append one pixel and queue the predictions it produces
  task automatic predict_next_pixel(input logic [7:0] px);
    int p [PRED_COUNT];
    int w;
    int W, WW, WWW, WWWW, WWWWW, WWWWWW;
    int N, NW, NWW, NWWW, NWWWW;
    int NE, NEE, NEEE, NEEEE, NEEEEE, NEEEEEE, NEEEEEEE;
    int NN, NNW, NNWW, NNWWW, NNE, NNEE, NNEEE, NNEEEE;
    int NNN, NNNW, NNNWW, NNNWWWW, NNNWWWWW, NNNE, NNNEE, NNNEEE, NNNEEEE;
    int NNNN, NNNNWWW, NNNNEEE, NNNNN, NNNNNN;
    pred_beat_t b;
    w = row_width;
    if (w < 8) w = 8;
    if (w > MAX_W) w = MAX_W;
    hist[hist_wr] = px;
    hist_wr = (hist_wr + 1) % HIST_LEN;

    W = tap(1); WW = tap(2); WWW = tap(3); WWWW = tap(4); WWWWW = tap(5);
    WWWWWW = tap(6);
    N = tap(w); NW = tap(w + 1); NWW = tap(w + 2); NWWW = tap(w + 3); NWWWW = tap(w + 4);
    NE = tap(w - 1); NEE = tap(w - 2); NEEE = tap(w - 3); NEEEE = tap(w - 4);
    NEEEEE = tap(w - 5); NEEEEEE = tap(w - 6); NEEEEEEE = tap(w - 7);
    NN = tap(2 * w); NNW = tap(2 * w + 1); NNWW = tap(2 * w + 2); NNWWW = tap(2 * w + 3);
    NNE = tap(2 * w - 1); NNEE = tap(2 * w - 2); NNEEE = tap(2 * w - 3);
    NNEEEE = tap(2 * w - 4);
    NNN = tap(3 * w); NNNW = tap(3 * w + 1); NNNWW = tap(3 * w + 2);
    NNNWWWW = tap(3 * w + 4); NNNWWWWW = tap(3 * w + 5);
    NNNE = tap(3 * w - 1); NNNEE = tap(3 * w - 2); NNNEEE = tap(3 * w - 3);
    NNNEEEE = tap(3 * w - 4);
    NNNN = tap(4 * w); NNNNWWW = tap(4 * w + 3); NNNNEEE = tap(4 * w - 3);
    NNNNN = tap(5 * w); NNNNNN = tap(6 * w);

    // Division on int truncates toward zero
    p[0]  = limit4(W + N - NW, W, NW, N, NE);
    p[1]  = sat8(W + N - NW);
    p[2]  = limit4(W + NE - N, W, NW, N, NE);
    p[3]  = sat8(W + NE - N);
    p[4]  = limit4(N + NW - NNW, W, NW, N, NE);
    p[5]  = sat8(N + NW - NNW);
    p[6]  = limit4(N + NE - NNE, W, N, NE, NEE);
    p[7]  = sat8(N + NE - NNE);
    p[8]  = (W + NEE) / 2;
    p[9]  = sat8(N * 3 - NN * 3 + NNN);
    p[10] = sat8(W * 3 - WW * 3 + WWW);
    p[11] = (W + sat8(NE * 3 - NNE * 3 + NNNE)) / 2;
    p[12] = (W + sat8(NEE * 3 - NNEEE * 3 + NNNEEEE)) / 2;
    p[13] = sat8(NN + NNNN - NNNNNN);
    p[14] = sat8(WW + WWWW - WWWWWW);
    p[15] = sat8((NNNNN - 6 * NNNN + 15 * NNN - 20 * NN + 15 * N
                  + limit4(W * 2 - NWW, W, NW, N, NN)) / 6);
    p[16] = sat8((-3 * WW + 8 * W
                  + limit4(NEE * 3 - NNEE * 3 + NNNEE, NE, NEE, NEEE, NEEEE)) / 6);
    p[17] = sat8(NN + NW - NNNW);
    p[18] = sat8(NN + NE - NNNE);
    p[19] = sat8((W * 2 + NW) - (WW + 2 * NWW) + NWWW);
    p[20] = sat8(((NW + NWW) / 2) * 3 - NNWWW * 3 + (NNNWWWW + NNNWWWWW) / 2);
    p[21] = sat8(NEE + NE - NNEEE);
    p[22] = sat8(NWW + WW - NWWWW);
    p[23] = sat8(((W + NW) * 3 - NWW * 6 + NWWW + NNWWW) / 2);
    p[24] = sat8((NE * 2 + NNE) - (NNEE + NNNEE * 2) + NNNNEEE);
    p[25] = NNNNNN;
    p[26] = (NEEEE + NEEEEEE) / 2;
    p[27] = (WWWW + WWWWWW) / 2;
    p[28] = (W + N + NEEEEE + NEEEEEEE) / 4;
    p[29] = sat8(NEEE + W - NEE);
    p[30] = sat8(4 * NNN - 3 * NNNN);
    p[31] = sat8(N + NN - NNN);
    p[32] = sat8(W + WW - WWW);
    p[33] = sat8(W + NEE - NE);
    p[34] = sat8(WW + NEE - N);
    p[35] = (sat8(W * 2 - NW) + sat8(W * 2 - NWW) + N + NE) / 4;
    p[36] = limit4(N * 2 - NN, W, N, NE, NEE);
    p[37] = (N + NNN) / 2;
    p[38] = sat8(NN + W - NNW);
    p[39] = sat8(NWW + N - NNWW);
    p[40] = sat8((4 * WWW - 15 * WW + 20 * W + sat8(NEE * 2 - NNEE)) / 10);
    p[41] = sat8((NNNEEE - 4 * NNEE + 6 * NE + sat8(W * 3 - NW * 3 + NNW)) / 4);
    p[42] = sat8((N * 2 + NE) - (NN + 2 * NNE) + NNNE);
    p[43] = sat8((NW * 2 + NNW) - (NNWW + NNNWW * 2) + NNNNWWW);
    p[44] = sat8(NNWW + W - NNWWW);
    p[45] = sat8((-NNNN + 5 * NNN - 10 * NN + 10 * N
                  + sat8(W * 4 - NWW * 6 + NNWWW * 4 - NNNWWWW)) / 5);
    p[46] = sat8(NEE + sat8(NEEE * 2 - NNEEEE) - NEEEE);
    p[47] = sat8(NW + W - NWW);
    p[48] = sat8((N * 2 + NW) - (NN + 2 * NNW) + NNNW);
    p[49] = sat8(NN + sat8(NEE * 2 - NNEEE) - NNE);
    p[50] = sat8((-WWWW + 5 * WWW - 10 * WW + 10 * W + sat8(NE * 2 - NNE)) / 5);
    p[51] = sat8((-WWWWW + 4 * WWWW - 5 * WWW + 5 * W + sat8(NE * 2 - NNE)) / 4);
    p[52] = sat8((WWW - 4 * WW + 6 * W + sat8(NE * 3 - NNE * 3 + NNNE)) / 4);
    p[53] = sat8((-NNEE + 3 * NE + sat8(W * 4 - NW * 6 + NNW * 4 - NNNW)) / 3);
    // Last predictor is left unclipped and may go negative
    p[54] = ((W + N) * 3 - NW * 2) / 4;

    for (int i = 0; i < PRED_COUNT; i++) begin
      b.idx   = 6'(i);
      b.value = 10'(p[i]);
      b.last  = (6'(i) == PRED_LAST);
      pending_preds.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one pixel beat; valid stays high afterward so back-to-back beats
  // never see a low/high pair in one step.
  task automatic send_pixel(input logic [7:0] v);
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < 26) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel       <= v;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predict_next_pixel(v);
  endtask

  // Drop valid, drain every expected result, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (pending_preds.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only called with the block idle
  task automatic write_width(input logic [12:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    row_width = int'(v);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall, checked at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_stall_on) begin
      result_stall <= ($urandom_range(99) < 26);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pred_beat_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending_preds.size() == 0) begin
        $display("%0t: unexpected result beat idx=%0d pred=%0d last=%0b", $time,
                 predictor_index, prediction, last_prediction);
        fail_count++;
      end else begin
        e = pending_preds.pop_front();
        if (predictor_index !== e.idx) begin
          $display("%0t: predictor_index expected %0d actual %0d", $time, e.idx,
                   predictor_index);
          fail_count++;
        end
        if (prediction !== e.value) begin
          $display("%0t: prediction[%0d] expected %0d actual %0d", $time, e.idx,
                   e.value, prediction);
          fail_count++;
        end
        if (last_prediction !== e.last) begin
          $display("%0t: last_prediction[%0d] expected %0b actual %0b", $time, e.idx,
                   e.last, last_prediction);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default width of 256; everything before the first pixel reads as zero
  task automatic test_early_pixels();
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'h7f);
  endtask

  // Narrowest row, driving the unclipped predictor to both of its extremes
  task automatic test_narrow_extremes();
    write_width(13'd8);
    // Lone bright NW with dark W and N: most negative
    send_pixel(8'hff);
    repeat (8) send_pixel(8'h00);
    // Dark NW with bright W and N: most positive
    send_pixel(8'h00);
    repeat (8) send_pixel(8'hff);
  endtask

  // Out-of-range widths saturate to the legal span
  task automatic test_width_saturation();
    write_width(13'd0);
    send_pixel(8'h55);
    send_pixel(8'haa);
    write_width(13'h1fff);
    send_pixel(8'h33);
    send_pixel(8'hcc);
  endtask

  // Random pixels across a range of row widths
  task automatic test_random_images();
    int n;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_width(13'(MAX_W));
        5: write_width(13'd8);
        default: write_width(13'($urandom_range(40, 8)));
      endcase
      // Middle phase runs with no idling on either side
      src_idle_on   = (ph != 3);
      sink_stall_on = (ph != 3);
      n = (ph == 0) ? 6 : 14 + $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        // Mostly smooth content so predictors land inside their range,
        // sometimes a full-scale jump
        if ($urandom_range(3) == 0) begin
          send_pixel(8'($urandom_range(255)));
        end else begin
          send_pixel(8'(int'(hist[(hist_wr + HIST_LEN - 1) % HIST_LEN])
                        + $urandom_range(16) - 8));
        end
      end
    end
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < HIST_LEN; i++) hist[i] = 8'h00;
    hist_wr   = 0;
    row_width = 256;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_early_pixels();
    test_narrow_extremes();
    test_width_saturation();
    test_random_images();
    drain_results();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
